@@ rtl/kclru_pkg.sv @@
// ----------------------------------------------------------------------------
// kclru_pkg - shared types and constants
// Table geometry, status codes, and the scan word and update command types
// passed along and across the cell chain.
// ----------------------------------------------------------------------------
package kclru_pkg;

   localparam int ENTRIES  = 32;
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int STAMP_W  = 32;
   localparam int STYLE_W  = 16;
   localparam int SIZE_W   = 8;
   localparam int REFS_W   = 8;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 5;

   localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSTALLED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FALLBACK  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DEFAULT   = 3'd4;

   typedef enum logic [1:0] {
      CMD_TOUCH   = 2'd0,
      CMD_INSTALL = 2'd1,
      CMD_EVICT   = 2'd2
   } kclru_cmd_kind_type;

   // scan word, one cell per cycle
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [IDX_W-1:0]   hit_idx;
      logic               have_empty;
      logic               have_victim;
      logic [IDX_W-1:0]   victim;
      logic [STAMP_W-1:0] oldest;
   } kclru_pkt_type;

   // end-of-scan update, broadcast to all cells
   typedef struct packed {
      logic               en;
      kclru_cmd_kind_type kind;
      logic [IDX_W-1:0]   idx;
      logic [STYLE_W-1:0] style;
      logic [SIZE_W-1:0]  size;
      logic [STAMP_W-1:0] stamp;
   } kclru_cmd_type;

endpackage

@@ rtl/keyed_cache_lru_refcount_top.sv @@
// ----------------------------------------------------------------------------
// keyed_cache_lru_refcount_top - keyed resource cache, LRU with ref counts
// Fully associative table built as a chain of cells; a scan word walks the
// chain one cell per cycle, then one update is broadcast to the chosen cell.
// ----------------------------------------------------------------------------
//  channel  | ports                                 | handshake
//  ---------+---------------------------------------+---------------------------
//  request  | req_style_key req_size_key req_open_ok | start & !busy takes word
//  response | rsp_status rsp_slot rsp_evicted        | rsp_valid, one cycle
//  config   | csr_wdata                              | csr_we, no wait
//
// From start to next start, a word passes the launch register, then the
// register of each cell of the scan chain, then the update cycle.
// The response strobe comes in the cycle after the update cycle; busy drops
// at the same edge, so the next word can be taken at the end of the strobe.
// Synchronous reset empties the table and clears the stamp counter.
// The receiver cannot stall; nothing waits on the response side.
// ----------------------------------------------------------------------------
module keyed_cache_lru_refcount_top
   import kclru_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [STYLE_W-1:0]  req_style_key,
   input  logic [SIZE_W-1:0]   req_size_key,
   input  logic                req_open_ok,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic                rsp_evicted,
   input  logic                csr_we,
   input  logic [STYLE_W-1:0]  csr_wdata
);

   logic                busy_ff, busy_in;
   logic                launch_ff;
   logic [STYLE_W-1:0]  style_ff, mask_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic                open_ff;
   logic [STAMP_W-1:0]  counter_ff, counter_in;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                evicted_ff, evicted_in;
   kclru_cmd_type       cmd;
   kclru_pkt_type       chain [ENTRIES+1];
   kclru_pkt_type       fin;
   logic                accept;

   assign accept = start && !busy_ff;

   // launch word enters cell 0 in the cycle after accept, key already held
   always_comb begin
      chain[0]             = '0;
      chain[0].valid       = launch_ff;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      kclru_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(i)),
         .key_style (style_ff),
         .key_size  (size_ff),
         .pkt_in    (chain[i]),
         .cmd       (cmd),
         .pkt_out   (chain[i+1])
      );
   end

   assign fin = chain[ENTRIES];

   // end of scan: decide the outcome and at most one table update
   always_comb begin
      cmd        = '0;
      cmd.kind   = CMD_TOUCH;
      cmd.style  = style_ff;
      cmd.size   = size_ff;
      cmd.stamp  = counter_ff;
      counter_in = counter_ff;
      status_in  = ST_FULL;
      slot_in    = '0;
      evicted_in = 1'b0;
      busy_in    = busy_ff;
      if (accept) busy_in = 1'b1;
      if (fin.valid) begin
         busy_in = 1'b0;
         if (fin.hit) begin
            status_in  = ST_HIT;
            slot_in    = SLOT_W'(fin.hit_idx);
            cmd.en     = 1'b1;
            cmd.idx    = fin.hit_idx;
            counter_in = counter_ff + 1'b1;
         end else if (fin.have_victim) begin
            slot_in    = SLOT_W'(fin.victim);
            evicted_in = !fin.have_empty;   // victim was occupied
            cmd.idx    = fin.victim;
            if (open_ff) begin
               status_in  = ST_INSTALLED;
               cmd.en     = 1'b1;
               cmd.kind   = CMD_INSTALL;
               counter_in = counter_ff + 1'b1;
            end else begin
               status_in = ((style_ff & mask_ff) != '0) ? ST_FALLBACK : ST_DEFAULT;
               cmd.en    = !fin.have_empty;
               cmd.kind  = CMD_EVICT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         counter_ff   <= '0;
         mask_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         launch_ff    <= accept;
         rsp_valid_ff <= fin.valid;
         counter_ff   <= counter_in;
         if (csr_we) mask_ff <= csr_wdata;
      end
      if (accept) begin
         style_ff <= req_style_key;
         size_ff  <= req_size_key;
         open_ff  <= req_open_ok;
      end
      status_ff  <= status_in;
      slot_ff    <= slot_in;
      evicted_ff <= evicted_in;
   end

   assign busy        = busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_slot    = slot_ff;
   assign rsp_evicted = evicted_ff;

   // a response never overlaps a word in flight
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff)
      else $error("response while busy");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (status_ff <= ST_DEFAULT))
      else $error("bad status code");

   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      (counter_ff != $past(counter_ff)) |-> rsp_valid_ff)
      else $error("stamp counter moved without a response");

   a_evict_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evicted) |-> (status_ff != ST_HIT && status_ff != ST_FULL))
      else $error("eviction flagged on hit or full");

endmodule

@@ rtl/kclru_cell.sv @@
// ----------------------------------------------------------------------------
// kclru_cell - one table entry and one scan stage
// Holds an entry, checks the passing scan word against it, forwards it.
// ----------------------------------------------------------------------------
module kclru_cell
   import kclru_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [IDX_W-1:0]   cell_idx,
   input  logic [STYLE_W-1:0] key_style,
   input  logic [SIZE_W-1:0]  key_size,
   input  kclru_pkt_type      pkt_in,
   input  kclru_cmd_type      cmd,
   output kclru_pkt_type      pkt_out
);

   logic               valid_ff, valid_in;
   logic [STYLE_W-1:0] style_ff, style_in;
   logic [SIZE_W-1:0]  size_ff,  size_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [REFS_W-1:0]  refs_ff,  refs_in;
   kclru_pkt_type      pkt_ff,   pkt_in_nx;
   logic               sel;

   always_comb begin
      pkt_in_nx = pkt_in;
      if (pkt_in.valid && !pkt_in.hit) begin
         if (valid_ff) begin
            if (style_ff == key_style && size_ff == key_size) begin
               pkt_in_nx.hit     = 1'b1;
               pkt_in_nx.hit_idx = cell_idx;
            end else if (!pkt_in.have_empty && refs_ff == '0 &&
                         (!pkt_in.have_victim || stamp_ff < pkt_in.oldest)) begin
               pkt_in_nx.have_victim = 1'b1;
               pkt_in_nx.oldest      = stamp_ff;
               pkt_in_nx.victim      = cell_idx;
            end
         end else begin
            pkt_in_nx.have_empty  = 1'b1;
            pkt_in_nx.have_victim = 1'b1;
            pkt_in_nx.victim      = cell_idx;
         end
      end
   end

   assign sel = cmd.en && (cmd.idx == cell_idx);

   always_comb begin
      valid_in = valid_ff;
      style_in = style_ff;
      size_in  = size_ff;
      stamp_in = stamp_ff;
      refs_in  = refs_ff;
      if (sel) begin
         unique case (cmd.kind)
            CMD_TOUCH: begin
               stamp_in = cmd.stamp;
               if (refs_ff != '1) refs_in = refs_ff + 1'b1;
            end
            CMD_INSTALL: begin
               valid_in = 1'b1;
               style_in = cmd.style;
               size_in  = cmd.size;
               stamp_in = cmd.stamp;
               refs_in  = REFS_W'(1);
            end
            CMD_EVICT: valid_in = 1'b0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         pkt_ff.valid <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         pkt_ff.valid <= pkt_in_nx.valid;
      end
      style_ff           <= style_in;
      size_ff            <= size_in;
      stamp_ff           <= stamp_in;
      refs_ff            <= refs_in;
      pkt_ff.hit         <= pkt_in_nx.hit;
      pkt_ff.hit_idx     <= pkt_in_nx.hit_idx;
      pkt_ff.have_empty  <= pkt_in_nx.have_empty;
      pkt_ff.have_victim <= pkt_in_nx.have_victim;
      pkt_ff.victim      <= pkt_in_nx.victim;
      pkt_ff.oldest      <= pkt_in_nx.oldest;
   end

   assign pkt_out = pkt_ff;

endmodule
